// File: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and defaults for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DQ_CAPACITY = 16;
    localparam int DQ_WORD_W   = 32;

    // operation codes carried in the func field
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_SHOW       = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]                  func;
        logic signed [DQ_WORD_W-1:0] value;
    } t_dq_in;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [DQ_WORD_W-1:0] word;
        logic                        last;
    } t_dq_out;

    // controller -> datapath
    typedef struct packed {
        logic       push_front;
        logic       push_back;
        logic       pop_front;
        logic       pop_back;
        logic       show;
        logic       clear;
        logic       emit_imm;   // load output from the immediate answer
        logic [1:0] imm_status;
        logic       emit_ram;   // load output from the read data
    } t_dq_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic left_zero;
        logic out_free;
    } t_dq_stat;

endpackage

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words held in a ring buffer, with push and
// pop at either end, clear, and a show operation that streams all words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | beat payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (func, value)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (status, word, last)
//
//  Push, clear, full and empty answers load the output register directly.
//  Pop: the word passes through the registered read of the word store port.
//  Show of N words: one word per cycle through the read port while the output is not stalled.
//  Reset (i_rst_n low, synchronous) empties the queue; no clearing pass.
//  A stalled output holds its beat; input is taken again once it drains.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dq_pkg::t_dq_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dq_pkg::t_dq_out o_out_data
);

    import dq_pkg::*;

    // command and status between sequencer and datapath
    t_dq_cmd  cmd;
    t_dq_stat stat;

    // decode the operation, pick immediate answer or stored-word stream
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_in_data.func),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold front pointer, count, word store and the output register
    dq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in_data.value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sv/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Operation decode and sequencing for the double-ended queue.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_func,
    input  dq_pkg::t_dq_stat i_stat,
    output dq_pkg::t_dq_cmd  o_cmd
);

    import dq_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic    r_state;
    logic    n_state;
    logic    in_ready;
    logic    accept;
    t_dq_cmd cmd;

    assign in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept   = in_ready && i_in_valid;

    always_comb begin
        cmd        = '0;
        cmd.imm_status = ST_OK;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_func) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            cmd.emit_imm = 1'b1;
                            if (i_stat.full) begin
                                cmd.imm_status = ST_FULL;
                            end else begin
                                cmd.push_front = (i_func == OP_PUSH_FRONT);
                                cmd.push_back  = (i_func == OP_PUSH_BACK);
                            end
                        end
                        OP_SHOW, OP_POP_FRONT, OP_POP_BACK: begin
                            if (i_stat.empty) begin
                                cmd.emit_imm   = 1'b1;
                                cmd.imm_status = ST_EMPTY;
                            end else begin
                                cmd.show      = (i_func == OP_SHOW);
                                cmd.pop_front = (i_func == OP_POP_FRONT);
                                cmd.pop_back  = (i_func == OP_POP_BACK);
                                n_state       = S_STREAM;
                            end
                        end
                        OP_CLEAR: begin
                            cmd.clear    = 1'b1;
                            cmd.emit_imm = 1'b1;
                        end
                        default: begin
                            // unused codes: drop the beat
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (i_stat.out_free) begin
                    cmd.emit_ram = 1'b1;
                    if (i_stat.left_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;

endmodule

// File: sv/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath
// Ring pointers, word store and output register of the double-ended queue.
// ----------------------------------------------------------------------------
module dq_dpath #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [dq_pkg::DQ_WORD_W-1:0] i_value,
    input  dq_pkg::t_dq_cmd                    i_cmd,
    output dq_pkg::t_dq_stat                   o_stat,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output dq_pkg::t_dq_out                    o_out_data
);

    import dq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

    logic [AW-1:0]          r_front;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_pos;
    logic [CW-1:0]          r_left;
    logic                   r_out_valid;
    t_dq_out                r_out;

    logic [AW-1:0]          front_dec;
    logic [AW-1:0]          front_inc;
    logic [AW-1:0]          pos_inc;
    logic [SW-1:0]          sum_tail;
    logic [SW-1:0]          sum_last;
    logic [AW-1:0]          tail_pos;
    logic [AW-1:0]          last_pos;
    logic                   out_free;
    logic                   left_zero;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [DQ_WORD_W-1:0]   rd_data;
    logic signed [DQ_WORD_W-1:0] imm_word;

    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign pos_inc   = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;

    // ring slot just past the back, and the back slot itself
    assign sum_tail = SW'(r_front) + SW'(r_count);
    assign sum_last = sum_tail - 1'b1;
    assign tail_pos = (sum_tail >= CAP_S) ? AW'(sum_tail - CAP_S) : AW'(sum_tail);
    assign last_pos = (sum_last >= CAP_S) ? AW'(sum_last - CAP_S) : AW'(sum_last);

    assign out_free  = !r_out_valid || i_out_ready;
    assign left_zero = (r_left == '0);

    assign wr_en   = i_cmd.push_front || i_cmd.push_back;
    assign wr_addr = i_cmd.push_front ? front_dec : tail_pos;

    assign rd_en   = i_cmd.pop_front || i_cmd.pop_back || i_cmd.show
                     || (i_cmd.emit_ram && !left_zero);
    assign rd_addr = i_cmd.pop_back ? last_pos :
                     (i_cmd.emit_ram ? pos_inc : r_front);

    assign imm_word = wr_en ? i_value : '0;

    dq_ram #(
        .WIDTH (DQ_WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_left  <= '0;
        end else begin
            if (i_cmd.push_front) begin
                r_front <= front_dec;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.push_back) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.pop_front) begin
                r_front <= front_inc;
                r_count <= r_count - 1'b1;
                r_left  <= '0;
            end
            if (i_cmd.pop_back) begin
                r_count <= r_count - 1'b1;
                r_left  <= '0;
            end
            if (i_cmd.show) begin
                r_pos  <= r_front;
                r_left <= r_count - 1'b1;
            end
            if (i_cmd.clear) begin
                r_front <= '0;
                r_count <= '0;
            end
            if (i_cmd.emit_ram && !left_zero) begin
                r_pos  <= pos_inc;
                r_left <= r_left - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_imm || i_cmd.emit_ram) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_imm) begin
            r_out.status <= i_cmd.imm_status;
            r_out.word   <= imm_word;
            r_out.last   <= 1'b1;
        end else if (i_cmd.emit_ram) begin
            r_out.status <= ST_OK;
            r_out.word   <= rd_data;
            r_out.last   <= left_zero;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(CAPACITY));
    assign o_stat.left_zero = left_zero;
    assign o_stat.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
